### rtl/core/skf_pkg.sv
// Shared types, constants and the control program for the scalar Kalman filter unit.
// Depends on nothing; every other file in rtl/core except skf_sample_if imports it.
`default_nettype none

package skf_pkg;

	// Fixed widths of the filter arithmetic
	localparam int VAR_W      = 32;            // variances, Q16.16
	localparam int GAIN_W     = 17;            // gain, Q0.16 with room for 1.0
	localparam int GAIN_FRAC  = 16;
	localparam int DEN_W      = VAR_W + 1;     // P1 + measurement variance
	localparam int REM_W      = DEN_W + 1;     // divider partial remainder
	localparam int PROD_W     = VAR_W + GAIN_W;
	localparam int INIT_EST_W = 24;            // width of the init_estimate register
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
	localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

	// Divider: one quotient bit per step, bit 16 down to bit 0
	localparam int DIV_STEPS = GAIN_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_VAR   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_VAR   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE = CFG_IDX_W'(3);

	// Register reset values
	localparam logic [VAR_W-1:0]      RST_PROCESS_VAR   = VAR_W'(0);
	localparam logic [VAR_W-1:0]      RST_MEASURE_VAR   = VAR_W'(65536);
	localparam logic [INIT_EST_W-1:0] RST_INIT_ESTIMATE = INIT_EST_W'(0);
	localparam logic [VAR_W-1:0]      RST_INIT_VARIANCE = VAR_W'(65536);

	// Datapath operations, one per control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,      // latch sample, grow variance
		OP_DENOM,     // divisor, remainder seed, |zq - est|
		OP_DIV,       // one restoring divide step
		OP_MUL_EST,   // product gain * difference
		OP_UPD_EST,   // round and apply estimate step, product P1 * (1 - gain)
		OP_UPD_VAR    // round variance, hand off the result
	} op_t;

	// Sequencing conditions
	typedef enum logic [2:0] {
		C_NEXT,       // fall through
		C_WAIT_IN,    // hold until an input transaction, then fall through
		C_DEN_ZERO,   // jump if the divisor is zero
		C_LOOP,       // jump while the step counter is not zero
		C_WAIT_OUT,   // hold until the output register is free, then jump
		C_JUMP        // unconditional jump
	} cond_t;

	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic den_zero;
	} stat_t;

	// Program store
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		case (pc)
			3'd0:    w = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: 3'd0};
			3'd1:    w = '{op: OP_DENOM,   cond: C_NEXT,     target: 3'd0};
			3'd2:    w = '{op: OP_NOP,     cond: C_DEN_ZERO, target: 3'd4};
			3'd3:    w = '{op: OP_DIV,     cond: C_LOOP,     target: 3'd3};
			3'd4:    w = '{op: OP_MUL_EST, cond: C_NEXT,     target: 3'd0};
			3'd5:    w = '{op: OP_UPD_EST, cond: C_NEXT,     target: 3'd0};
			3'd6:    w = '{op: OP_UPD_VAR, cond: C_WAIT_OUT, target: 3'd0};
			default: w = '{op: OP_NOP,     cond: C_JUMP,     target: 3'd0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/skf_sample_if.sv
// Input channel of the scalar Kalman filter unit: valid/ready plus one ADC sample.
// Depends on nothing.
`default_nettype none

interface skf_sample_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### rtl/core/skf_result_if.sv
// Result channel of the scalar Kalman filter unit: valid/ready, estimate and gain.
// Depends on skf_pkg for the gain width.
`default_nettype none

interface skf_result_if
	import skf_pkg::*;
#(
	parameter int EST_BITS = 24
);
	logic                valid;
	logic                ready;
	logic [EST_BITS-1:0] estimate;
	logic [GAIN_W-1:0]   gain;

	modport source (output valid, output estimate, output gain, input ready);
	modport sink   (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

### rtl/core/skf_cfg_if.sv
// Register write channel of the scalar Kalman filter unit: valid/ready, index and data.
// Depends on skf_pkg for the index and data widths.
`default_nettype none

interface skf_cfg_if
	import skf_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/scalar_kalman_filter_unit.sv
// Scalar Kalman filter unit: one sample in, one estimate and gain out.
// A new sample is taken only after the last one has finished its final program step; the
// 17-step restoring gain divider shares a single compare-subtract stage and is skipped when
// the divisor is zero; a held output stalls the last step.
// Reset: registers go to their reset values, estimate 0 and variance 1.0, no result pending.
// Depends on skf_pkg, the three channel interfaces, skf_sequencer and skf_datapath.
`default_nettype none

module scalar_kalman_filter_unit
	import skf_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS   = 12
)(
	input wire logic clk,
	input wire logic arst_n,
	skf_sample_if.sink   samp_ch,
	skf_result_if.source res_ch,
	skf_cfg_if.sink      cfg_ch
);

	localparam int EST_BITS = SAMPLE_BITS + FRAC_BITS;

	logic [VAR_W-1:0]      pv_q;
	logic [VAR_W-1:0]      mv_q;
	logic [INIT_EST_W-1:0] ie_q;
	logic [VAR_W-1:0]      iv_q;
	logic [INIT_EST_W-1:0] ie_d;
	logic [VAR_W-1:0]      iv_d;
	logic                  cfg_wr;
	logic                  reload;

	logic                  out_valid_q;
	logic [EST_BITS-1:0]   out_est_q;
	logic [GAIN_W-1:0]     out_gain_q;
	logic                  out_free;

	ctrl_t                 ctrl;
	stat_t                 stat;
	logic [EST_BITS-1:0]   dp_est;
	logic [GAIN_W-1:0]     dp_gain;

	// Register writes are always taken
	assign cfg_ch.ready = 1'b1;
	assign cfg_wr       = cfg_ch.valid;

	// Any write inside the register map reloads the filter state
	always_comb begin
		ie_d   = ie_q;
		iv_d   = iv_q;
		reload = 1'b0;
		if (cfg_wr) begin
			case (cfg_ch.index)
				REG_PROCESS_VAR, REG_MEASURE_VAR: begin
					reload = 1'b1;
				end
				REG_INIT_ESTIMATE: begin
					ie_d   = cfg_ch.data[INIT_EST_W-1:0];
					reload = 1'b1;
				end
				REG_INIT_VARIANCE: begin
					iv_d   = cfg_ch.data[VAR_W-1:0];
					reload = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= RST_PROCESS_VAR;
			mv_q <= RST_MEASURE_VAR;
			ie_q <= RST_INIT_ESTIMATE;
			iv_q <= RST_INIT_VARIANCE;
		end else begin
			if (cfg_wr && cfg_ch.index == REG_PROCESS_VAR) begin
				pv_q <= cfg_ch.data[VAR_W-1:0];
			end
			if (cfg_wr && cfg_ch.index == REG_MEASURE_VAR) begin
				mv_q <= cfg_ch.data[VAR_W-1:0];
			end
			ie_q <= ie_d;
			iv_q <= iv_d;
		end
	end

	// Control program
	assign out_free = !out_valid_q || res_ch.ready;

	skf_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samp_ch.valid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (samp_ch.ready),
		.ctrl     (ctrl)
	);

	skf_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.EST_BITS    (EST_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (samp_ch.sample),
		.process_var (pv_q),
		.measure_var (mv_q),
		.reload      (reload),
		.reload_est  (EST_BITS'(ie_d)),
		.reload_var  (iv_d),
		.estimate    (dp_est),
		.gain        (dp_gain),
		.stat        (stat)
	);

	// Output register, loaded on the last program step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_UPD_VAR && ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_UPD_VAR && ctrl.fire) begin
			out_est_q  <= dp_est;
			out_gain_q <= dp_gain;
		end
	end

	assign res_ch.valid    = out_valid_q;
	assign res_ch.estimate = out_est_q;
	assign res_ch.gain     = out_gain_q;

endmodule

`default_nettype wire

### rtl/core/skf_sequencer.sv
// Microcode sequencer: program counter, divide step counter and condition logic.
// Depends on skf_pkg for the program store and control types.
`default_nettype none

module skf_sequencer
	import skf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  out_free,
	input  wire stat_t stat,
	output      logic  in_ready,
	output      ctrl_t ctrl
);

	pc_t              pc_q;
	pc_t              pc_d;
	logic [CNT_W-1:0] cnt_q;
	uword_t           uw;
	logic             fire;

	assign uw = ucode(pc_q);

	// Action enable for the current control word
	always_comb begin
		case (uw.cond)
			C_WAIT_IN:  fire = in_valid;
			C_WAIT_OUT: fire = out_free;
			default:    fire = 1'b1;
		endcase
	end

	assign in_ready  = (uw.cond == C_WAIT_IN);
	assign ctrl.op   = uw.op;
	assign ctrl.fire = fire;

	// Next program counter
	always_comb begin
		case (uw.cond)
			C_NEXT:     pc_d = pc_q + 1'b1;
			C_WAIT_IN:  pc_d = fire ? pc_q + 1'b1 : pc_q;
			C_DEN_ZERO: pc_d = stat.den_zero ? uw.target : pc_q + 1'b1;
			C_LOOP:     pc_d = (cnt_q != '0) ? uw.target : pc_q + 1'b1;
			C_WAIT_OUT: pc_d = fire ? uw.target : pc_q;
			C_JUMP:     pc_d = uw.target;
			default:    pc_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Divide step counter: loaded with the step count less one, counts down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (uw.op == OP_DENOM) begin
			cnt_q <= CNT_W'(DIV_STEPS - 1);
		end else if (uw.op == OP_DIV && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/skf_datapath.sv
// Filter datapath: state registers, restoring divider, one shared multiplier.
// Depends on skf_pkg for widths, operations and control types.
`default_nettype none

module skf_datapath
	import skf_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS   = 12,
	parameter int EST_BITS    = SAMPLE_BITS + FRAC_BITS
)(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ctrl_t                  ctrl,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [VAR_W-1:0]       process_var,
	input  wire logic [VAR_W-1:0]       measure_var,
	input  wire logic                   reload,
	input  wire logic [EST_BITS-1:0]    reload_est,
	input  wire logic [VAR_W-1:0]       reload_var,
	output      logic [EST_BITS-1:0]    estimate,
	output      logic [GAIN_W-1:0]      gain,
	output      stat_t                  stat
);

	logic [EST_BITS-1:0] est_q;
	logic [VAR_W-1:0]    var_q;
	logic [VAR_W-1:0]    p1_q;
	logic [EST_BITS-1:0] zq_q;
	logic [DEN_W-1:0]    den_q;
	logic [REM_W-1:0]    rem_q;
	logic [GAIN_W-1:0]   k_q;
	logic [EST_BITS-1:0] diff_q;
	logic                up_q;
	logic [PROD_W-1:0]   prod_q;

	logic [DEN_W-1:0]    grow;
	logic [VAR_W-1:0]    p1;
	logic                ge;
	logic [REM_W-1:0]    rem_keep;
	logic [VAR_W-1:0]    mul_a;
	logic [GAIN_W-1:0]   mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [PROD_W-1:0]   rnd;
	logic [EST_BITS-1:0] step;
	logic                act;

	assign act = ctrl.fire;

	// Variance growth, saturating
	assign grow = {1'b0, var_q} + {1'b0, process_var};
	assign p1   = grow[VAR_W] ? {VAR_W{1'b1}} : grow[VAR_W-1:0];

	// Restoring divide step
	assign ge       = (rem_q >= {1'b0, den_q});
	assign rem_keep = ge ? rem_q - {1'b0, den_q} : rem_q;

	// Shared multiplier: gain * difference, then P1 * (1 - gain)
	assign mul_a = (ctrl.op == OP_UPD_EST) ? p1_q : VAR_W'(diff_q);
	assign mul_b = (ctrl.op == OP_UPD_EST) ? GAIN_ONE - k_q : k_q;
	assign mul_p = mul_a * mul_b;

	// Round half up and drop the gain fraction
	assign rnd  = prod_q + HALF_LSB;
	assign step = rnd[GAIN_FRAC +: EST_BITS];

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= EST_BITS'(RST_INIT_ESTIMATE);
			var_q <= RST_INIT_VARIANCE;
		end else if (reload) begin
			est_q <= reload_est;
			var_q <= reload_var;
		end else if (act && ctrl.op == OP_UPD_EST) begin
			est_q <= up_q ? est_q + step : est_q - step;
		end else if (act && ctrl.op == OP_UPD_VAR) begin
			var_q <= rnd[GAIN_FRAC +: VAR_W];
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (act) begin
			case (ctrl.op)
				OP_LOAD: begin
					p1_q <= p1;
					zq_q <= EST_BITS'(sample) << FRAC_BITS;
				end
				OP_DENOM: begin
					den_q  <= {1'b0, p1_q} + {1'b0, measure_var};
					rem_q  <= REM_W'(p1_q);
					k_q    <= '0;
					up_q   <= (zq_q >= est_q);
					diff_q <= (zq_q >= est_q) ? zq_q - est_q : est_q - zq_q;
				end
				OP_DIV: begin
					rem_q <= {rem_keep[REM_W-2:0], 1'b0};
					k_q   <= {k_q[GAIN_W-2:0], ge};
				end
				OP_MUL_EST, OP_UPD_EST: begin
					prod_q <= mul_p;
				end
				default: begin
				end
			endcase
		end
	end

	assign estimate     = est_q;
	assign gain         = k_q;
	assign stat.den_zero = (den_q == '0);

endmodule

`default_nettype wire

### tb/scalar_kalman_filter_unit_test.sv
// Self-checking testbench for scalar_kalman_filter_unit: random and directed ADC samples,
// register writes between phases, and a bit-exact fixed-point filter predictor.
// Depends on skf_pkg, the three channel interfaces and the filter unit RTL.

module scalar_kalman_filter_unit_test;
	import skf_pkg::*;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 12;
	localparam int EST_BITS    = SAMPLE_BITS + FRAC_BITS;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 200;
	localparam int RANDOM_PHASES = 9;
	localparam logic [63:0] VAR_CEIL = 64'hFFFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = CFG_IDX_W'(255);

	typedef struct packed {
		logic [EST_BITS-1:0] estimate;
		logic [GAIN_W-1:0]   gain;
	} filter_out_t;

	logic clk;
	logic arst_n;

	skf_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samp_bus ();
	skf_result_if #(.EST_BITS(EST_BITS))       res_bus ();
	skf_cfg_if                                 cfg_bus ();

	scalar_kalman_filter_unit #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samp_ch(samp_bus),
		.res_ch (res_bus),
		.cfg_ch (cfg_bus)
	);

	// Samples waiting to be sent and filter outputs waiting to be seen
	logic [SAMPLE_BITS-1:0] pending_samples[$];
	filter_out_t            expected_outputs[$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;

	// Register copies and filter state of the predictor
	logic [VAR_W-1:0]      reg_process_var;
	logic [VAR_W-1:0]      reg_measure_var;
	logic [INIT_EST_W-1:0] reg_init_estimate;
	logic [VAR_W-1:0]      reg_init_variance;
	logic [EST_BITS-1:0]   filt_estimate;
	logic [VAR_W-1:0]      filt_variance;

	// One filter step: grow variance, compute gain, pull estimate, shrink variance
	function automatic filter_out_t advance_filter(input logic [SAMPLE_BITS-1:0] adc);
		logic [63:0] var_grown, divisor, gain, target, diff, step, est_next;
		filter_out_t result;
		var_grown = {32'b0, filt_variance} + {32'b0, reg_process_var};
		if (var_grown > VAR_CEIL)
			var_grown = VAR_CEIL;
		divisor = var_grown + {32'b0, reg_measure_var};
		gain = (divisor == 64'd0) ? 64'd0 : (var_grown << GAIN_FRAC) / divisor;
		target = {52'b0, adc} << FRAC_BITS;
		if (target >= {40'b0, filt_estimate}) begin
			diff = target - {40'b0, filt_estimate};
			step = (gain * diff + 64'(HALF_LSB)) >> GAIN_FRAC;
			est_next = {40'b0, filt_estimate} + step;
		end else begin
			diff = {40'b0, filt_estimate} - target;
			step = (gain * diff + 64'(HALF_LSB)) >> GAIN_FRAC;
			est_next = {40'b0, filt_estimate} - step;
		end
		filt_estimate = est_next[EST_BITS-1:0];
		est_next = (var_grown * (64'(GAIN_ONE) - gain) + 64'(HALF_LSB)) >> GAIN_FRAC;
		filt_variance = est_next[VAR_W-1:0];
		result.estimate = filt_estimate;
		result.gain = gain[GAIN_W-1:0];
		return result;
	endfunction

	function automatic void reload_filter();
		filt_estimate = EST_BITS'(reg_init_estimate);
		filt_variance = reg_init_variance;
	endfunction

	// Variance values biased toward the ends and toward small magnitudes
	function automatic logic [VAR_W-1:0] pick_variance();
		logic [VAR_W-1:0] v;
		case ($urandom_range(5))
			0:       v = '0;
			1:       v = '1;
			2:       v = $urandom;
			default: v = $urandom >> $urandom_range(31);
		endcase
		return v;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#3000000;
		$display("scalar_kalman_filter_unit regression: fail");
		$finish;
	end

	// Sample driver: predict on each accepted transaction, keep valid up until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			samp_bus.valid <= 1'b0;
		end else begin
			if (samp_bus.valid && samp_bus.ready)
				expected_outputs.push_back(advance_filter(samp_bus.sample));
			if (!samp_bus.valid || samp_bus.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					samp_bus.valid <= 1'b1;
					samp_bus.sample <= pending_samples.pop_front();
				end else begin
					samp_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest prediction, random backpressure
	always @(posedge clk) begin
		filter_out_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_outputs.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result estimate=%h gain=%h", $time,
						res_bus.estimate, res_bus.gain);
				end else begin
					want = expected_outputs.pop_front();
					if (res_bus.estimate !== want.estimate) begin
						error_count++;
						$display("%0t: estimate expected %h actual %h", $time,
							want.estimate, res_bus.estimate);
					end
					if (res_bus.gain !== want.gain) begin
						error_count++;
						$display("%0t: gain expected %h actual %h", $time,
							want.gain, res_bus.gain);
					end
				end
			end
			res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Register write transaction; the predictor follows once it is accepted
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		bit mapped;
		mapped = 1'b1;
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_PROCESS_VAR:   reg_process_var = value;
			REG_MEASURE_VAR:   reg_measure_var = value;
			REG_INIT_ESTIMATE: reg_init_estimate = value[INIT_EST_W-1:0];
			REG_INIT_VARIANCE: reg_init_variance = value;
			default:           mapped = 1'b0;
		endcase
		if (mapped)
			reload_filter();
	endtask

	// Wait until every sample is sent and every result is back, then let the unit settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || samp_bus.valid || expected_outputs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Stimulus sequence
	initial begin
		int level;
		int pick;
		arst_n = 1'b0;
		samp_bus.valid = 1'b0;
		samp_bus.sample = '0;
		res_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		error_count = 0;
		send_idle_pct = 38;
		recv_idle_pct = 61;
		reg_process_var = RST_PROCESS_VAR;
		reg_measure_var = RST_MEASURE_VAR;
		reg_init_estimate = RST_INIT_ESTIMATE;
		reg_init_variance = RST_INIT_VARIANCE;
		reload_filter();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings, sample extremes and alternating bit patterns
		pending_samples = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'h000};
		wait_drained();

		// Zero divisor, estimate at full scale: nothing should move
		write_reg(REG_PROCESS_VAR, '0);
		write_reg(REG_MEASURE_VAR, '0);
		write_reg(REG_INIT_VARIANCE, '0);
		write_reg(REG_INIT_ESTIMATE, 32'hFFFF_FFFF);
		pending_samples = '{12'h000, 12'hFFF};
		wait_drained();

		// Variance growth saturates
		write_reg(REG_PROCESS_VAR, 32'hFFFF_FFFF);
		write_reg(REG_MEASURE_VAR, 32'hFFFF_FFFF);
		write_reg(REG_INIT_VARIANCE, 32'hFFFF_FFFF);
		pending_samples = '{12'hFFF, 12'h000, 12'h800};
		wait_drained();

		// No measurement noise: gain of exactly one
		write_reg(REG_MEASURE_VAR, '0);
		write_reg(REG_PROCESS_VAR, 32'h0001_0000);
		write_reg(REG_INIT_VARIANCE, 32'h0000_0001);
		pending_samples = '{12'h123, 12'hFFF, 12'h001};
		wait_drained();

		// Writes outside the register map change nothing, state carries on
		write_reg(REG_UNMAPPED, $urandom);
		write_reg(REG_INDEX_TOP, 32'hFFFF_FFFF);
		pending_samples = '{12'hFFE, 12'h7FF};
		wait_drained();

		// Random phases: receiver-heavy idling, sender-heavy idling, then none
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle_pct = (p < 3) ? 38 : (p < 6) ? 61 : 0;
			recv_idle_pct = (p < 3) ? 61 : (p < 6) ? 38 : 0;
			write_reg(REG_PROCESS_VAR, pick_variance());
			write_reg(REG_MEASURE_VAR, pick_variance());
			write_reg(REG_INIT_VARIANCE, pick_variance());
			case ($urandom_range(3))
				0:       write_reg(REG_INIT_ESTIMATE, '0);
				1:       write_reg(REG_INIT_ESTIMATE, 32'h00FF_FFFF);
				default: write_reg(REG_INIT_ESTIMATE, $urandom);
			endcase
			if ($urandom_range(3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_INDEX_TOP, REG_UNMAPPED)), $urandom);
			// Mostly a noisy wandering level, with full-range jumps and rail hits
			level = $urandom_range(4095);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(9);
				if (pick < 2) begin
					pending_samples.push_back(SAMPLE_BITS'($urandom_range(4095)));
				end else if (pick == 2) begin
					pending_samples.push_back($urandom_range(1) ? 12'hFFF : 12'h000);
				end else begin
					level = level + $urandom_range(64) - 32;
					if (level < 0)
						level = 0;
					if (level > 4095)
						level = 4095;
					pending_samples.push_back(SAMPLE_BITS'(level));
				end
			end
			wait_drained();
		end

		if (error_count == 0) begin
			$display("scalar_kalman_filter_unit regression: pass");
		end else begin
			$display("scalar_kalman_filter_unit regression: fail");
		end
		$finish;
	end

endmodule
